// File: rtl/turtle_vector_pen_top_assert.svh
// Assertion macros for the pen engine modules; tvp_back includes them.
`ifndef TURTLE_VECTOR_PEN_TOP_ASSERT_SVH
`define TURTLE_VECTOR_PEN_TOP_ASSERT_SVH

// Property that holds in the same cycle.
`define TVP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property whose consequent holds in the next cycle.
`define TVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tvp_pkg.sv
package tvp_pkg;

  // operation codes
  localparam logic [2:0] OP_SET_POSE   = 3'd0;
  localparam logic [2:0] OP_FORWARD    = 3'd1;
  localparam logic [2:0] OP_TURN_RIGHT = 3'd2;
  localparam logic [2:0] OP_TURN_LEFT  = 3'd3;
  localparam logic [2:0] OP_SET_PEN    = 3'd4;

  localparam int OP_W   = 3;
  localparam int POSE_W = 16;
  localparam int TURN_W = 16;
  localparam int DIST_W = 15;
  localparam int GAIN_W = 30;
  localparam int PROD_W = DIST_W + GAIN_W;
  localparam int XY_W   = 34;   // Q8 plus 16 guard bits, with headroom for the CORDIC gain
  localparam int Z_W    = 32;   // residual angle, 2^32 = one full turn
  localparam int DX_W   = XY_W - 16;

  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam int START_XY = 6400;

  typedef struct packed {
    logic                     is_pose;
    logic                     emit;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic [Z_W-1:0]           z;
    logic signed [POSE_W-1:0] pose_x;
    logic signed [POSE_W-1:0] pose_y;
  } item_t;

  function automatic logic [Z_W-1:0] atan_entry(input int idx);
    logic [Z_W-1:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/tvp_front.sv
module tvp_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tvp_pkg::OP_W-1:0]         operation,
  input  logic signed [tvp_pkg::POSE_W-1:0] pose_x,
  input  logic signed [tvp_pkg::POSE_W-1:0] pose_y,
  input  logic [tvp_pkg::POSE_W-1:0]       pose_heading,
  input  logic [tvp_pkg::DIST_W-1:0]       distance,
  input  logic [tvp_pkg::TURN_W-1:0]       turn_amount,
  input  logic                             pen_value,
  input  logic                             down_free,
  output tvp_pkg::item_t                   item,
  output logic                             valid
);

  logic [ANGLE_BITS-1:0]         heading;
  logic                          pen_lowered;
  logic                          free;
  logic                          accept;
  logic [tvp_pkg::Z_W-1:0]       z_raw;
  logic                          flip;
  logic [tvp_pkg::PROD_W-1:0]    prod;
  logic signed [tvp_pkg::XY_W-1:0] x_mag;
  tvp_pkg::item_t                item_next;

  assign free     = !valid || down_free;
  assign in_stall = !free;
  assign accept   = in_valid && free;

  assign z_raw = tvp_pkg::Z_W'(heading) << (tvp_pkg::Z_W - ANGLE_BITS);
  // second or third quarter: start from the negated vector, half a turn on
  assign flip  = z_raw[tvp_pkg::Z_W-1] ^ z_raw[tvp_pkg::Z_W-2];
  assign prod  = tvp_pkg::PROD_W'(distance) * tvp_pkg::PROD_W'(tvp_pkg::GAIN_Q30);
  assign x_mag = $signed(tvp_pkg::XY_W'(prod[tvp_pkg::PROD_W-1:14]));

  always_comb begin
    item_next.is_pose = (operation == tvp_pkg::OP_SET_POSE);
    item_next.emit    = pen_lowered;
    item_next.x       = flip ? -x_mag : x_mag;
    item_next.y       = '0;
    item_next.z       = {z_raw[tvp_pkg::Z_W-1] ^ flip, z_raw[tvp_pkg::Z_W-2:0]};
    item_next.pose_x  = pose_x;
    item_next.pose_y  = pose_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      heading     <= ANGLE_BITS'(1) << (ANGLE_BITS - 2);
      pen_lowered <= 1'b1;
    end else begin
      if (free) begin
        valid <= in_valid && (operation == tvp_pkg::OP_SET_POSE ||
                              operation == tvp_pkg::OP_FORWARD);
      end
      if (accept) begin
        case (operation)
          tvp_pkg::OP_SET_POSE:   heading     <= ANGLE_BITS'(pose_heading);
          tvp_pkg::OP_TURN_RIGHT: heading     <= heading - ANGLE_BITS'(turn_amount);
          tvp_pkg::OP_TURN_LEFT:  heading     <= heading + ANGLE_BITS'(turn_amount);
          tvp_pkg::OP_SET_PEN:    pen_lowered <= pen_value;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      item <= item_next;
    end
  end

endmodule

// File: rtl/tvp_cell.sv
module tvp_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  tvp_pkg::item_t up_item,
  input  logic           up_valid,
  input  logic           down_free,
  output tvp_pkg::item_t item,
  output logic           valid,
  output logic           free
);

  localparam logic [tvp_pkg::Z_W-1:0] ATAN = tvp_pkg::atan_entry(IDX);

  logic signed [tvp_pkg::XY_W-1:0] xs;
  logic signed [tvp_pkg::XY_W-1:0] ys;
  tvp_pkg::item_t                  item_next;

  assign free = !valid || down_free;
  assign xs   = $signed(up_item.x) >>> IDX;
  assign ys   = $signed(up_item.y) >>> IDX;

  // one micro-rotation towards zero residual angle
  always_comb begin
    item_next = up_item;
    if (!up_item.z[tvp_pkg::Z_W-1]) begin
      item_next.x = up_item.x - ys;
      item_next.y = up_item.y + xs;
      item_next.z = up_item.z - ATAN;
    end else begin
      item_next.x = up_item.x + ys;
      item_next.y = up_item.y - xs;
      item_next.z = up_item.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      item <= item_next;
    end
  end

endmodule

// File: rtl/tvp_back.sv
module tvp_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tvp_pkg::item_t               up_item,
  input  logic                         up_valid,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] start_x,
  output logic signed [COORD_BITS-1:0] start_y,
  output logic signed [COORD_BITS-1:0] end_x,
  output logic signed [COORD_BITS-1:0] end_y
);

  localparam int SUM_W = ((COORD_BITS > tvp_pkg::DX_W) ? COORD_BITS : tvp_pkg::DX_W) + 1;
  localparam logic signed [SUM_W-1:0] C_HI =
    {{(SUM_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] C_LO = ~C_HI;

  logic signed [COORD_BITS-1:0]       pos_x;
  logic signed [COORD_BITS-1:0]       pos_y;
  logic signed [COORD_BITS-1:0]       pos_x_next;
  logic signed [COORD_BITS-1:0]       pos_y_next;
  logic [tvp_pkg::XY_W-1:0]           rx;
  logic [tvp_pkg::XY_W-1:0]           ry;
  logic signed [tvp_pkg::DX_W-1:0]    dx;
  logic signed [tvp_pkg::DX_W-1:0]    dy;
  logic                               load;
  logic                               emit;

  function automatic logic signed [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > C_HI) begin
      r = C_HI[COORD_BITS-1:0];
    end else if (v < C_LO) begin
      r = C_LO[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign free = !out_valid || !out_stall;
  assign load = free && up_valid;
  assign emit = !up_item.is_pose && up_item.emit;

  // round the offsets to Q8: add half, drop the guard bits
  assign rx = up_item.x + tvp_pkg::XY_W'(32768);
  assign ry = up_item.y + tvp_pkg::XY_W'(32768);
  assign dx = $signed(rx[tvp_pkg::XY_W-1:16]);
  assign dy = $signed(ry[tvp_pkg::XY_W-1:16]);

  always_comb begin
    if (up_item.is_pose) begin
      pos_x_next = clamp({{(SUM_W - tvp_pkg::POSE_W){up_item.pose_x[tvp_pkg::POSE_W-1]}},
                          up_item.pose_x});
      pos_y_next = clamp({{(SUM_W - tvp_pkg::POSE_W){up_item.pose_y[tvp_pkg::POSE_W-1]}},
                          up_item.pose_y});
    end else begin
      pos_x_next = clamp({{(SUM_W - COORD_BITS){pos_x[COORD_BITS-1]}}, pos_x} +
                         {{(SUM_W - tvp_pkg::DX_W){dx[tvp_pkg::DX_W-1]}}, dx});
      pos_y_next = clamp({{(SUM_W - COORD_BITS){pos_y[COORD_BITS-1]}}, pos_y} +
                         {{(SUM_W - tvp_pkg::DX_W){dy[tvp_pkg::DX_W-1]}}, dy});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos_x     <= COORD_BITS'(tvp_pkg::START_XY);
      pos_y     <= COORD_BITS'(tvp_pkg::START_XY);
    end else begin
      if (free) begin
        out_valid <= up_valid && emit;
      end
      if (load) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      start_x <= pos_x;
      start_y <= pos_y;
      end_x   <= pos_x_next;
      end_y   <= pos_y_next;
    end
  end

`include "turtle_vector_pen_top_assert.svh"

  `TVP_ASSERT_NEXT(a_no_phantom, !out_valid && !(up_valid && emit), !out_valid, "segment without source")
  `TVP_ASSERT_NEXT(a_end_is_pos, load && emit, end_x == pos_x && end_y == pos_y, "segment end off position")
  `TVP_ASSERT_NEXT(a_pose_silent, load && up_item.is_pose, !out_valid, "set pose gave a segment")

endmodule

// File: rtl/turtle_vector_pen_top.sv
// Turtle pen engine: keeps position, heading and pen flag, and turns drawing
// commands into line segments.
// Input channel: one command per request (operation plus its operand fields),
// taken at an edge where in_valid is high and in_stall low.
// Output channel: one segment per forward command issued with the pen down,
// taken at an edge where out_valid is high and out_stall low.
// Turns, set pen and unknown operations act at the front and leave no trace
// further on; set pose and forward travel the rotation chain so that the
// position is updated strictly in command order.
// Path: a taken request passes the front register, one cell per rotation step
// and the output register before its segment is shown.
// Throughput: one request per cycle when not stalled (one step per cell).
// Stall: a held segment freezes only the tail; requests are still taken while
// any stage of the chain is empty, and in_stall rises once every stage is full.
// Reset: position 25.0, 25.0; heading a quarter turn; pen down; chain empty.
module turtle_vector_pen_top #(
  parameter int COORD_BITS    = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tvp_pkg::OP_W-1:0]          operation,
  input  logic signed [tvp_pkg::POSE_W-1:0] pose_x,
  input  logic signed [tvp_pkg::POSE_W-1:0] pose_y,
  input  logic [tvp_pkg::POSE_W-1:0]        pose_heading,
  input  logic [tvp_pkg::DIST_W-1:0]        distance,
  input  logic [tvp_pkg::TURN_W-1:0]        turn_amount,
  input  logic                              pen_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      start_x,
  output logic signed [COORD_BITS-1:0]      start_y,
  output logic signed [COORD_BITS-1:0]      end_x,
  output logic signed [COORD_BITS-1:0]      end_y
);

  // stage k feeds cell k; the last stage feeds the position unit
  tvp_pkg::item_t stage_item  [0:CORDIC_STAGES];
  logic           stage_valid [0:CORDIC_STAGES];
  // cell_free[k]: cell k can take a request this cycle
  logic           cell_free   [0:CORDIC_STAGES];

  // heading and pen live here; forward requests get their start vector
  tvp_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .pose_x       (pose_x),
    .pose_y       (pose_y),
    .pose_heading (pose_heading),
    .distance     (distance),
    .turn_amount  (turn_amount),
    .pen_value    (pen_value),
    .down_free    (cell_free[0]),
    .item         (stage_item[0]),
    .valid        (stage_valid[0])
  );

  // rotation chain: each cell applies one micro-rotation and hands on
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    tvp_cell #(
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_item   (stage_item[k]),
      .up_valid  (stage_valid[k]),
      .down_free (cell_free[k+1]),
      .item      (stage_item[k+1]),
      .valid     (stage_valid[k+1]),
      .free      (cell_free[k])
    );
  end

  // position update, saturation and the output register
  tvp_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .up_item   (stage_item[CORDIC_STAGES]),
    .up_valid  (stage_valid[CORDIC_STAGES]),
    .free      (cell_free[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y)
  );

endmodule
